// File: src/srt_pkg.sv
// Package for the sorted region table: request/response types, table entry,
// status codes and controller states. No dependencies.
package srt_pkg;

    localparam int ADDR_W = 48;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] region_start;
        logic [ADDR_W-1:0] region_end;
        logic [7:0]        region_mode;
        logic [7:0]        file_id;
        logic [ADDR_W-1:0] lookup_addr;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [5:0]        entry_index;
        logic [ADDR_W-1:0] hit_start;
        logic [ADDR_W-1:0] hit_end;
        logic [7:0]        hit_mode;
        logic [7:0]        hit_file;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic [7:0]        mode;
        logic [7:0]        file;
    } entry_t;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [2:0] ST_INSERTED     = 3'd0;
    localparam logic [2:0] ST_MERGED_NEXT  = 3'd1;
    localparam logic [2:0] ST_MERGED_LAST  = 3'd2;
    localparam logic [2:0] ST_FULL         = 3'd3;
    localparam logic [2:0] ST_DUPLICATE    = 3'd4;
    localparam logic [2:0] ST_FOUND        = 3'd5;
    localparam logic [2:0] ST_NOT_FOUND    = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_PLACE,
        S_RESULT
    } state_t;

endpackage

// File: src/srt_mem.sv
// Region entry memory: one write port, one read port, registered read data.
// Depends on srt_pkg for the entry type.
module srt_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  srt_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output srt_pkg::entry_t rd_data
);

    srt_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/sorted_region_table.sv
// Sorted region table. Holds up to MAX_REGIONS address regions (start, end,
// mode, file id) sorted by start address in a single-port-read, single-port-
// write entry memory. One request is worked on at a time. Every request, lookup
// or insert, reads all entries in order in the scan state, and a decision
// state follows. Lookups, merges and rejects then go to the result state, which
// loads the response register. An insert that adds a region at position pos
// below the top first moves the entries at and above pos up one slot, one per
// cycle, and every added region is then written in the place state. The
// result waits in the result state while an earlier response is stalled and
// is then loaded into an output register; the next request is taken the
// cycle after the response is loaded.
module sorted_region_table #(
    parameter int MAX_REGIONS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  srt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output srt_pkg::rsp_t rsp
);

    localparam int IW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);

    // state
    srt_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    srt_pkg::req_t   req_reg, req_next;

    // scan pipeline: issue index, then data in the next cycle
    logic [CW-1:0]   issue_reg, issue_next;
    logic            rvalid_reg, rvalid_next;
    logic [IW-1:0]   ridx_reg, ridx_next;

    // scan findings
    logic            found_reg, found_next;
    logic [IW-1:0]   hit_idx_reg, hit_idx_next;
    srt_pkg::entry_t hit_reg, hit_next;
    logic            dup_reg, dup_next;
    logic [IW-1:0]   dup_idx_reg, dup_idx_next;
    logic            pfound_reg, pfound_next;
    logic [CW-1:0]   pos_reg, pos_next;
    srt_pkg::entry_t pent_reg, pent_next;
    srt_pkg::entry_t last_reg, last_next;

    // shift pointer
    logic [IW-1:0]   sh_reg, sh_next;
    logic            sh_busy_reg, sh_busy_next;

    srt_pkg::rsp_t   res_reg, res_next;
    logic            rsp_valid_reg, rsp_valid_next;
    srt_pkg::rsp_t   rsp_reg, rsp_next;

    // memory port
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    srt_pkg::entry_t wr_data;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    srt_pkg::entry_t rd_data;

    logic            accept;
    logic            new_ok;
    logic [CW+5:0]   idx_ext;

    srt_mem #(
        .DEPTH(MAX_REGIONS),
        .AW   (IW)
    ) u_mem (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign req_stall = (state_reg != srt_pkg::S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srt_pkg::S_IDLE;
            count_reg     <= '0;
            rvalid_reg    <= 1'b0;
            sh_busy_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rvalid_reg    <= rvalid_next;
            sh_busy_reg   <= sh_busy_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        issue_reg   <= issue_next;
        ridx_reg    <= ridx_next;
        found_reg   <= found_next;
        hit_idx_reg <= hit_idx_next;
        hit_reg     <= hit_next;
        dup_reg     <= dup_next;
        dup_idx_reg <= dup_idx_next;
        pfound_reg  <= pfound_next;
        pos_reg     <= pos_next;
        pent_reg    <= pent_next;
        last_reg    <= last_next;
        sh_reg      <= sh_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        req_next       = req_reg;
        issue_next     = issue_reg;
        rvalid_next    = 1'b0;
        ridx_next      = ridx_reg;
        found_next     = found_reg;
        hit_idx_next   = hit_idx_reg;
        hit_next       = hit_reg;
        dup_next       = dup_reg;
        dup_idx_next   = dup_idx_reg;
        pfound_next    = pfound_reg;
        pos_next       = pos_reg;
        pent_next      = pent_reg;
        last_next      = last_reg;
        sh_next        = sh_reg;
        sh_busy_next   = sh_busy_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        new_ok         = 1'b0;
        idx_ext        = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            srt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    req_next    = req;
                    issue_next  = '0;
                    found_next  = 1'b0;
                    dup_next    = 1'b0;
                    pfound_next = 1'b0;
                    pos_next    = count_reg;
                    res_next    = '0;
                    state_next  = srt_pkg::S_SCAN;
                end
            end

            srt_pkg::S_SCAN:
            begin
                // issue reads in order
                if (issue_reg < count_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = issue_reg[IW-1:0];
                    rvalid_next = 1'b1;
                    ridx_next   = issue_reg[IW-1:0];
                    issue_next  = issue_reg + CW'(1);
                end
                // examine the entry read last cycle
                if (rvalid_reg)
                begin
                    if (req_reg.command == srt_pkg::CMD_LOOKUP)
                    begin
                        if (!found_reg && rd_data.start_addr <= req_reg.lookup_addr
                            && req_reg.lookup_addr < rd_data.end_addr)
                        begin
                            found_next   = 1'b1;
                            hit_idx_next = ridx_reg;
                            hit_next     = rd_data;
                        end
                    end
                    else
                    begin
                        if (!dup_reg && rd_data.start_addr == req_reg.region_start)
                        begin
                            dup_next     = 1'b1;
                            dup_idx_next = ridx_reg;
                        end
                        if (!pfound_reg && req_reg.region_start < rd_data.start_addr)
                        begin
                            pfound_next = 1'b1;
                            pos_next    = CW'(ridx_reg);
                            pent_next   = rd_data;
                        end
                        if (CW'(ridx_reg) == count_reg - CW'(1))
                        begin
                            last_next = rd_data;
                        end
                    end
                end
                if (issue_reg >= count_reg && !rvalid_reg)
                begin
                    state_next = srt_pkg::S_DECIDE;
                end
            end

            srt_pkg::S_DECIDE:
            begin
                state_next = srt_pkg::S_RESULT;
                if (req_reg.command == srt_pkg::CMD_LOOKUP)
                begin
                    if (found_reg)
                    begin
                        idx_ext               = (CW+6)'(hit_idx_reg);
                        res_next.status       = srt_pkg::ST_FOUND;
                        res_next.entry_index  = idx_ext[5:0];
                        res_next.hit_start    = hit_reg.start_addr;
                        res_next.hit_end      = hit_reg.end_addr;
                        res_next.hit_mode     = hit_reg.mode;
                        res_next.hit_file     = hit_reg.file;
                    end
                    else
                    begin
                        res_next.status = srt_pkg::ST_NOT_FOUND;
                    end
                end
                else if (dup_reg)
                begin
                    idx_ext              = (CW+6)'(dup_idx_reg);
                    res_next.status      = srt_pkg::ST_DUPLICATE;
                    res_next.entry_index = idx_ext[5:0];
                end
                else if (pfound_reg && req_reg.region_end == pent_reg.start_addr
                         && req_reg.region_mode == pent_reg.mode
                         && req_reg.file_id == pent_reg.file)
                begin
                    // lower the start of the following entry
                    wr_en                = 1'b1;
                    wr_addr              = pos_reg[IW-1:0];
                    wr_data              = pent_reg;
                    wr_data.start_addr   = req_reg.region_start;
                    idx_ext              = (CW+6)'(pos_reg);
                    res_next.status      = srt_pkg::ST_MERGED_NEXT;
                    res_next.entry_index = idx_ext[5:0];
                end
                else if (!pfound_reg && count_reg != '0
                         && last_reg.end_addr == req_reg.region_start
                         && req_reg.region_mode == last_reg.mode
                         && req_reg.file_id == last_reg.file)
                begin
                    // extend the last entry
                    wr_en                = 1'b1;
                    wr_addr              = IW'(count_reg - CW'(1));
                    wr_data              = last_reg;
                    wr_data.end_addr     = req_reg.region_end;
                    idx_ext              = (CW+6)'(count_reg - CW'(1));
                    res_next.status      = srt_pkg::ST_MERGED_LAST;
                    res_next.entry_index = idx_ext[5:0];
                end
                else if (count_reg >= CW'(MAX_REGIONS))
                begin
                    res_next.status = srt_pkg::ST_FULL;
                end
                else
                begin
                    new_ok = 1'b1;
                end

                if (new_ok)
                begin
                    if (pos_reg < count_reg)
                    begin
                        sh_next      = IW'(count_reg - CW'(1));
                        sh_busy_next = 1'b1;
                        state_next   = srt_pkg::S_SHIFT;
                    end
                    else
                    begin
                        state_next = srt_pkg::S_PLACE;
                    end
                end
            end

            srt_pkg::S_SHIFT:
            begin
                // read entry i, write it to i+1 next cycle, from the top down
                if (sh_busy_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = sh_reg;
                    rvalid_next = 1'b1;
                    ridx_next   = sh_reg;
                    if (sh_reg == pos_reg[IW-1:0])
                    begin
                        sh_busy_next = 1'b0;
                    end
                    else
                    begin
                        sh_next = sh_reg - IW'(1);
                    end
                end
                if (rvalid_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = ridx_reg + IW'(1);
                    wr_data = rd_data;
                end
                if (!sh_busy_reg && !rvalid_reg)
                begin
                    state_next = srt_pkg::S_PLACE;
                end
            end

            srt_pkg::S_PLACE:
            begin
                wr_en                = 1'b1;
                wr_addr              = pos_reg[IW-1:0];
                wr_data.start_addr   = req_reg.region_start;
                wr_data.end_addr     = req_reg.region_end;
                wr_data.mode         = req_reg.region_mode;
                wr_data.file         = req_reg.file_id;
                count_next           = count_reg + CW'(1);
                idx_ext              = (CW+6)'(pos_reg);
                res_next.status      = srt_pkg::ST_INSERTED;
                res_next.entry_index = idx_ext[5:0];
                state_next           = srt_pkg::S_RESULT;
            end

            srt_pkg::S_RESULT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = srt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = srt_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_REGIONS))
        else $error("entry count above table size");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == srt_pkg::S_DECIDE || state_reg == srt_pkg::S_SHIFT
                   || state_reg == srt_pkg::S_PLACE))
        else $error("memory write outside insert phases");

    a_shift_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srt_pkg::S_SHIFT && wr_en) |-> (CW'(wr_addr) > pos_reg))
        else $error("shift wrote at or below insert position");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == srt_pkg::S_PLACE))
        else $error("entry count changed outside placement");
`endif

endmodule
